// ===== src/sfs_pkg.sv =====
// Starfield frame step: shared types and constants.
// No dependencies.
package sfs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN_H,
    ST_SPAWN_V,
    ST_SPAWN_Z,
    ST_SPAWN_ZMOD,
    ST_EASE,
    ST_MOVE,
    ST_RESP_V,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_OUT
  } state_t;

  localparam logic [1:0] MODE_BUILD = 2'd0;
  localparam logic [1:0] MODE_DRIVE = 2'd1;
  localparam logic [1:0] MODE_IDLE  = 2'd2;

  localparam logic [8:0] Z_NEAR       = 9'h00A;
  localparam logic [8:0] Z_ONE        = 9'h100;
  localparam logic [8:0] Z_SPAWN_MIN  = 9'h00C;
  localparam logic [8:0] Z_SPAWN_SPAN = 9'h0F4;
  localparam logic [7:0] DRIVE_TARGET = 8'd48;
  localparam logic [31:0] SEED_RESET  = 32'd2463534242;

  // one xorshift32 step
  function automatic logic [31:0] xs_next(input logic [31:0] x);
    logic [31:0] a, b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // nonzero signed byte from a draw
  function automatic logic signed [7:0] nz_byte(input logic [31:0] x);
    logic [7:0] b;
    b = x[15:8];
    return (b == 8'd0) ? 8'sd1 : $signed(b);
  endfunction

endpackage

// ===== src/starfield_frame_step_unit.sv =====
// Starfield frame step top level: sequencer, star store and shared divider.
// Depends on sfs_pkg.
//
// Usage:
//   One request on the in_ channel is one frame tick (mode, warp). The block
//   then emits NUM_STARS results on the out_ channel, star 0 first, with
//   out_last_star on the final one. in_ready is low while a frame is busy,
//   and also while cfg_valid is high (a seed write goes first when idle).
//   The cfg_ channel loads the generator seed; write it only while idle.
// Divider and timing:
//   One shared 24-bit restoring divider (one quotient bit a cycle) serves
//   all projections of a star: four divisions for a visible star and two
//   for an off-screen one. A frame runs the store read, the move step, any
//   respawn, the divisions and the result for each star in turn, and it
//   stalls in the result state while out_ready is low. The first frame adds
//   the scatter, whose depth modulo is a short compare-subtract loop.
// Reset:
//   Velocity clears, the generator reloads the reset seed, the stars are
//   scattered on the first frame. The star store needs no clearing.
// Stall:
//   Each result is held in an output register until out_ready; the
//   sequencer waits there, so no result is lost under backpressure.
module starfield_frame_step_unit #(
  parameter int NUM_STARS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_boot_mode,
  input  logic [7:0]          in_warp_level,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_seed_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          out_star_number,
  output logic signed [15:0]  out_tail_x,
  output logic signed [15:0]  out_tail_y,
  output logic signed [15:0]  out_head_x,
  output logic signed [15:0]  out_head_y,
  output logic                out_on_screen,
  output logic                out_as_line,
  output logic                out_last_star
);
  import sfs_pkg::*;

  localparam int IW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;
  localparam int CW = $clog2(NUM_STARS + 1);

  // star store
  logic signed [7:0] horiz_mem [NUM_STARS];
  logic signed [7:0] vert_mem  [NUM_STARS];
  logic [8:0]        depth_mem [NUM_STARS];

  state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          scatter_r, scatter_nxt;
  logic          ready_r, ready_nxt;
  logic [7:0]    vel_r, vel_nxt;
  logic [31:0]   gen_r, gen_nxt;
  logic [1:0]    mode_r;
  logic [7:0]    warp_r;
  logic signed [7:0] h_r, h_nxt, v_r, v_nxt;
  logic [8:0]    z_r, z_nxt;
  logic [15:0]   mod_r, mod_nxt;
  // divider
  logic [1:0]    dsel_r, dsel_nxt;
  logic [23:0]   quo_r, quo_nxt;
  logic [8:0]    rem_r, rem_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic          dneg_r, dneg_nxt;
  logic signed [15:0] hx_r, hx_nxt, hy_r, hy_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic          vis_r, vis_nxt;
  logic          we;
  logic          ld;
  logic [IW-1:0] idx;

  // combinational helpers
  logic [31:0]   gnext;
  logic signed [23:0] num;
  logic [23:0]   anum;
  logic [8:0]    dz, zp;
  logic [9:0]    zsum, trial;
  logic [23:0]   qsgn;
  logic signed [15:0] pres;
  logic signed [15:0] ddx, ddy;
  logic [15:0]   adx, ady;
  logic          line;
  logic [7:0]    target;
  logic [1:0]    shift;
  logic [7:0]    up, dn;

  assign idx = idx_r[IW-1:0];
  assign in_ready = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign gnext = xs_next(gen_r);
  // store read for the next star
  assign ld = (state_r == ST_EASE) || (state_r == ST_RESP_V);

  always_comb begin
    num = (dsel_r[1] ? 24'(signed'(v_r)) : 24'(signed'(h_r))) * 24'sd6656;
    anum = num[23] ? -num : num;
    zsum = {1'b0, z_r} + {2'b0, vel_r};
    zp = (zsum > {1'b0, Z_ONE}) ? Z_ONE : zsum[8:0];
    dz = dsel_r[0] ? zp : z_r;
    if (dz == 9'd0) dz = 9'd1;
    trial = {rem_r, quo_r[23]} - {1'b0, dz};
    qsgn = dneg_r ? -quo_r : quo_r;
    pres = qsgn[15:0] + (dsel_r[1] ? 16'sd32 : 16'sd64);
    ddx = hx_r - tx_r;
    ddy = hy_r - ty_r;
    adx = ddx[15] ? -ddx : ddx;
    ady = ddy[15] ? -ddy : ddy;
    line = !((adx == 16'd0 || adx == 16'd1) && (ady == 16'd0 || ady == 16'd1)
             && !(adx == 16'd1 && ady == 16'd1));
  end

  // easing
  always_comb begin
    unique case (mode_r)
      MODE_DRIVE: begin target = DRIVE_TARGET; shift = 2'd1; end
      MODE_IDLE:  begin target = 8'd1;         shift = 2'd2; end
      default:    begin target = 8'd2 + {4'd0, warp_r[7:4]}; shift = 2'd2; end
    endcase
    up = vel_r + 8'((({1'b0, target} - {1'b0, vel_r}) + ((9'd1 << shift) - 9'd1)) >> shift);
    dn = vel_r - ((vel_r - target) >> shift);
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; scatter_nxt = scatter_r;
    ready_nxt = ready_r; vel_nxt = vel_r; gen_nxt = gen_r;
    h_nxt = h_r; v_nxt = v_r; z_nxt = z_r; mod_nxt = mod_r;
    dsel_nxt = dsel_r; quo_nxt = quo_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r;
    dneg_nxt = dneg_r; hx_nxt = hx_r; hy_nxt = hy_r; tx_nxt = tx_r;
    ty_nxt = ty_r; vis_nxt = vis_r; we = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) gen_nxt = cfg_seed_value;
        else if (in_valid) begin
          idx_nxt = '0;
          scatter_nxt = !ready_r;
          ready_nxt = 1'b1;
          state_nxt = ready_r ? ST_EASE : ST_SPAWN_H;
        end
      end
      ST_SPAWN_H: begin
        gen_nxt = gnext; h_nxt = nz_byte(gnext);
        state_nxt = ST_SPAWN_V;
      end
      ST_SPAWN_V: begin
        gen_nxt = gnext; v_nxt = nz_byte(gnext);
        state_nxt = ST_SPAWN_Z;
        // a respawn lands at depth 1.0 and is not moved this frame
        if (!scatter_r) begin
          z_nxt = Z_ONE; we = 1'b1;
          dsel_nxt = 2'd0; state_nxt = ST_DIV_START;
        end
      end
      ST_SPAWN_Z: begin
        gen_nxt = gnext; mod_nxt = gnext[23:8];
        state_nxt = ST_SPAWN_ZMOD;
      end
      ST_SPAWN_ZMOD: begin
        // draw mod span by repeated subtract of shifted span
        if (mod_r >= 16'(Z_SPAWN_SPAN) << 8) mod_nxt = mod_r - (16'(Z_SPAWN_SPAN) << 8);
        else if (mod_r >= 16'(Z_SPAWN_SPAN) << 4) mod_nxt = mod_r - (16'(Z_SPAWN_SPAN) << 4);
        else if (mod_r >= 16'(Z_SPAWN_SPAN)) mod_nxt = mod_r - 16'(Z_SPAWN_SPAN);
        else begin
          z_nxt = Z_SPAWN_MIN + mod_r[8:0]; we = 1'b1;
          if (idx_r == CW'(NUM_STARS - 1)) begin
            idx_nxt = '0; state_nxt = ST_EASE;
          end else begin
            idx_nxt = idx_r + 1'b1; state_nxt = ST_SPAWN_H;
          end
        end
      end
      ST_EASE: begin
        vel_nxt = (target > vel_r) ? up : dn;
        idx_nxt = '0;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        // z, h, v hold the star's stored values
        state_nxt = ST_DIV_START;
        dsel_nxt = 2'd0;
        if ({1'b0, z_r} <= {1'b0, vel_r} + 10'(Z_NEAR)) begin
          state_nxt = ST_SPAWN_H; scatter_nxt = 1'b0;
        end else begin
          z_nxt = z_r - {1'b0, vel_r}; we = 1'b1;
        end
      end
      ST_DIV_START: begin
        quo_nxt = anum; rem_nxt = '0; dcnt_nxt = 5'd24; dneg_nxt = num[23];
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (!trial[9]) begin
          rem_nxt = trial[8:0]; quo_nxt = {quo_r[22:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[7:0], quo_r[23]}; quo_nxt = {quo_r[22:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == 5'd1) state_nxt = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        unique case (dsel_r)
          2'd0: begin hx_nxt = pres; dsel_nxt = 2'd2; state_nxt = ST_DIV_START; end
          2'd2: begin
            hy_nxt = pres;
            vis_nxt = !(hx_r < -16'sd4 || hx_r > 16'sd132 || pres < -16'sd4
                        || pres > 16'sd68);
            if (vis_nxt) begin dsel_nxt = 2'd1; state_nxt = ST_DIV_START; end
            else begin tx_nxt = '0; ty_nxt = '0; state_nxt = ST_OUT; end
          end
          2'd1: begin tx_nxt = pres; dsel_nxt = 2'd3; state_nxt = ST_DIV_START; end
          default: begin ty_nxt = pres; state_nxt = ST_OUT; end
        endcase
      end
      ST_OUT: begin
        if (out_ready) begin
          if (idx_r == CW'(NUM_STARS - 1)) state_nxt = ST_IDLE;
          else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = ST_RESP_V;
          end
        end
      end
      ST_RESP_V: begin
        state_nxt = ST_MOVE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; idx_r <= '0; scatter_r <= 1'b0; ready_r <= 1'b0;
      vel_r <= '0; gen_r <= SEED_RESET; dsel_r <= '0; dcnt_r <= '0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; scatter_r <= scatter_nxt;
      ready_r <= ready_nxt; vel_r <= vel_nxt; gen_r <= gen_nxt;
      dsel_r <= dsel_nxt; dcnt_r <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && !cfg_valid) begin
      mode_r <= in_boot_mode; warp_r <= in_warp_level;
    end
    if (ld) begin
      z_r <= depth_mem[idx]; h_r <= horiz_mem[idx]; v_r <= vert_mem[idx];
    end else begin
      h_r <= h_nxt; v_r <= v_nxt; z_r <= z_nxt;
    end
    mod_r <= mod_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; dneg_r <= dneg_nxt;
    hx_r <= hx_nxt; hy_r <= hy_nxt; tx_r <= tx_nxt; ty_r <= ty_nxt;
    vis_r <= vis_nxt;
    if (we) begin
      horiz_mem[idx] <= h_nxt; vert_mem[idx] <= v_nxt; depth_mem[idx] <= z_nxt;
    end
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_star_number = 5'(idx_r);
  assign out_tail_x      = tx_r;
  assign out_tail_y      = ty_r;
  assign out_head_x      = hx_r;
  assign out_head_y      = hy_r;
  assign out_on_screen   = vis_r;
  assign out_as_line     = vis_r & line;
  assign out_last_star   = (idx_r == CW'(NUM_STARS - 1));

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head_x))
    else $error("result dropped");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_star |=> cfg_ready)
    else $error("frame not closed");
endmodule

// ===== dv/starfield_frame_step_unit_tb.sv =====
// Testbench for starfield_frame_step_unit: frame ticks in, per-star streaks out.
// Self-checking; predicts every star result from its own frame model.
// Depends on sfs_pkg and the starfield_frame_step_unit RTL.
`timescale 1ns / 100ps

module starfield_frame_step_unit_tb;
  import sfs_pkg::*;

  localparam int STARS = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [4:0]         star_number;
    logic signed [15:0] tail_x;
    logic signed [15:0] tail_y;
    logic signed [15:0] head_x;
    logic signed [15:0] head_y;
    logic               on_screen;
    logic               as_line;
    logic               last_star;
  } star_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_boot_mode = '0;
  logic [7:0] in_warp_level = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_seed_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_star_number;
  logic signed [15:0] out_tail_x, out_tail_y, out_head_x, out_head_y;
  logic out_on_screen, out_as_line, out_last_star;

  // frame model state
  logic [31:0] gen_word;
  int          star_h[STARS];
  int          star_v[STARS];
  int          star_z[STARS];
  int          velocity;
  bit          scattered;

  star_result_t streak_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int gap_max = 17;
  int stall_max = 17;
  int stall_left = 0;

  starfield_frame_step_unit #(.NUM_STARS(STARS)) dut (.*);

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // xorshift32 draw, returns bits 8..23
  task automatic draw16(output int val);
    gen_word = gen_word ^ (gen_word << 13);
    gen_word = gen_word ^ (gen_word >> 17);
    gen_word = gen_word ^ (gen_word << 5);
    val = int'(gen_word[23:8]);
  endtask

  task automatic spawn_star(input int i, input bit scatter);
    int d;
    logic signed [7:0] b;
    draw16(d); b = d[7:0]; star_h[i] = (b == 0) ? 1 : int'(b);
    draw16(d); b = d[7:0]; star_v[i] = (b == 0) ? 1 : int'(b);
    if (scatter) begin
      draw16(d);
      star_z[i] = int'(Z_SPAWN_MIN) + d % int'(Z_SPAWN_SPAN);
    end else begin
      star_z[i] = int'(Z_ONE);
    end
  endtask

  function automatic logic signed [15:0] screen_pos(input int num, input int z, input int ctr);
    int d;
    d = (z == 0) ? 1 : z;
    return 16'(ctr + num / d);
  endfunction

  // advance one frame and queue the expected streak of each star
  task automatic compute_frame(input logic [1:0] mode, input logic [7:0] warp);
    int target, shift, nx, ny, zp;
    longint adx, ady;
    logic signed [15:0] dx, dy;
    star_result_t r;
    if (!scattered) begin
      for (int i = 0; i < STARS; i++) spawn_star(i, 1'b1);
      scattered = 1'b1;
    end
    if (mode == MODE_DRIVE) begin
      target = int'(DRIVE_TARGET); shift = 1;
    end else if (mode == MODE_IDLE) begin
      target = 1; shift = 2;
    end else begin
      target = 2 + (warp >> 4); shift = 2;
    end
    if (target > velocity) velocity += (target - velocity + (1 << shift) - 1) >> shift;
    else velocity -= (velocity - target) >> shift;
    velocity &= 8'hFF;
    // move closer, respawn past the near plane
    for (int i = 0; i < STARS; i++) begin
      if (star_z[i] <= velocity + int'(Z_NEAR)) spawn_star(i, 1'b0);
      else star_z[i] = (star_z[i] - velocity) & 9'h1FF;
    end
    for (int i = 0; i < STARS; i++) begin
      nx = star_h[i] * 26 * 256;
      ny = star_v[i] * 26 * 256;
      r.star_number = 5'(i);
      r.head_x = screen_pos(nx, star_z[i], 64);
      r.head_y = screen_pos(ny, star_z[i], 32);
      r.tail_x = '0; r.tail_y = '0; r.on_screen = 1'b0; r.as_line = 1'b0;
      if (!(r.head_x < -4 || r.head_x > 132 || r.head_y < -4 || r.head_y > 68)) begin
        zp = star_z[i] + velocity;
        if (zp > int'(Z_ONE)) zp = int'(Z_ONE);
        r.tail_x = screen_pos(nx, zp, 64);
        r.tail_y = screen_pos(ny, zp, 32);
        dx = r.head_x - r.tail_x;
        dy = r.head_y - r.tail_y;
        adx = (dx < 0) ? -longint'(dx) : longint'(dx);
        ady = (dy < 0) ? -longint'(dy) : longint'(dy);
        r.on_screen = 1'b1;
        r.as_line = (adx * adx + ady * ady >= 2);
      end
      r.last_star = (i == STARS - 1);
      streak_q.push_back(r);
    end
  endtask

  // one frame request, predicted when accepted
  task automatic send_frame(input logic [1:0] mode, input logic [7:0] warp);
    repeat ($urandom_range(gap_max, 0)) @(posedge clk);
    in_valid <= 1'b1;
    in_boot_mode <= mode;
    in_warp_level <= warp;
    do @(posedge clk); while (!in_ready);
    compute_frame(mode, warp);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained;
    while (streak_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_seed_value <= seed;
    do @(posedge clk); while (!cfg_ready);
    gen_word = seed;
    cfg_valid <= 1'b0;
  endtask

  // result stall: random hold-off before each result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      stall_left = $urandom_range(stall_max, 0);
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    star_result_t w;
    if (rst_n) begin
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (streak_q.size() == 0) begin
          report_mismatch("unexpected result, star", out_star_number, -1);
        end else begin
          w = streak_q.pop_front();
          if (out_star_number !== w.star_number)
            report_mismatch("star_number", out_star_number, w.star_number);
          if (out_tail_x !== w.tail_x) report_mismatch("tail_x", out_tail_x, w.tail_x);
          if (out_tail_y !== w.tail_y) report_mismatch("tail_y", out_tail_y, w.tail_y);
          if (out_head_x !== w.head_x) report_mismatch("head_x", out_head_x, w.head_x);
          if (out_head_y !== w.head_y) report_mismatch("head_y", out_head_y, w.head_y);
          if (out_on_screen !== w.on_screen)
            report_mismatch("on_screen", out_on_screen, w.on_screen);
          if (out_as_line !== w.as_line) report_mismatch("as_line", out_as_line, w.as_line);
          if (out_last_star !== w.last_star)
            report_mismatch("last_star", out_last_star, w.last_star);
        end
      end
    end
  end

  // default seed, first scatter, build and spare modes at warp extremes, idle mode
  task automatic test_modes;
    send_frame(MODE_BUILD, 8'd0);
    send_frame(MODE_BUILD, 8'd255);
    send_frame(MODE_SPARE, 8'd255);
    send_frame(MODE_SPARE, 8'd0);
    send_frame(MODE_IDLE, 8'h5A);
    send_frame(MODE_IDLE, 8'hA5);
  endtask

  // drive burst ramps velocity to the top, many near-plane respawns
  task automatic test_drive_burst;
    repeat (6) send_frame(MODE_DRIVE, 8'($urandom));
    repeat (3) send_frame(MODE_IDLE, 8'($urandom));
  endtask

  // seed extremes, with the sender held until the queue is empty
  task automatic test_seed_extremes;
    write_seed(32'h0000_0001);
    wait_drained();
    send_frame(MODE_DRIVE, 8'd255);
    send_frame(MODE_DRIVE, 8'd0);
    write_seed(32'hFFFF_FFFF);
    send_frame(MODE_DRIVE, 8'd255);
    send_frame(MODE_BUILD, 8'd255);
    write_seed($urandom_range(32'hFFFF_FFFF, 1));
    send_frame(MODE_DRIVE, 8'd17);
  endtask

  // runs of one mode with random warp; some runs with no idling
  task automatic test_random_frames(input int count);
    int sent, run;
    logic [1:0] mode;
    sent = 0;
    while (sent < count) begin
      mode = 2'($urandom_range(3, 0));
      run = $urandom_range(8, 1);
      if ($urandom_range(3, 0) == 0) begin
        gap_max = 0; stall_max = 0;
      end else begin
        gap_max = 17; stall_max = 17;
      end
      for (int k = 0; k < run && sent < count; k++) begin
        send_frame(mode, 8'($urandom));
        sent++;
      end
      if ($urandom_range(9, 0) == 0) write_seed($urandom_range(32'hFFFF_FFFF, 1));
    end
    gap_max = 17; stall_max = 17;
  endtask

  initial begin
    gen_word = SEED_RESET;
    velocity = 0;
    scattered = 1'b0;
    foreach (star_z[i]) begin
      star_h[i] = 0; star_v[i] = 0; star_z[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_modes();
    test_drive_burst();
    test_seed_extremes();
    test_random_frames(120);
    while (streak_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && streak_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sfs_pkg.sv
src/starfield_frame_step_unit.sv
dv/starfield_frame_step_unit_tb.sv
